@@ rtl/maxima_chain_box_search_assert.svh @@
// ============================================================================
// maxima_chain_box_search assertion macros
// shared concurrent assertion forms, sampled on clk and off during reset
// ============================================================================
`ifndef MAXIMA_CHAIN_BOX_SEARCH_ASSERT_SVH
`define MAXIMA_CHAIN_BOX_SEARCH_ASSERT_SVH

// same-cycle implication
`define MCBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mcbs_pkg.sv @@
// ============================================================================
// mcbs_pkg
// widths, codes and the cell word of the maxima chaining grid
// ============================================================================
package mcbs_pkg;

    localparam int MAX_EDGE    = 32;
    localparam int EDGE_BITS   = 6;
    localparam int COORD_BITS  = 5;
    localparam int POS_BITS    = 15;
    localparam int CELLS       = 32768;
    localparam int MAG_BITS    = 32;
    localparam int SIM_BITS    = 16;
    localparam int TAG_BITS    = 16;
    localparam int RAD_BITS    = 3;
    localparam int CNT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_CHAIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_X      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Y      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Z      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOX_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIMILARITY  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_SCALE = 3'd5;

    typedef struct packed {
        logic                valid;
        logic                linked;
        logic [MAG_BITS-1:0] mag;
        logic [POS_BITS-1:0] link_pos;
        logic [TAG_BITS-1:0] link_tag;
    } cell_t;

    // zero acts as one, anything above the edge limit as the limit
    function automatic logic [EDGE_BITS-1:0] eff_size(input logic [EDGE_BITS-1:0] s);
        logic [EDGE_BITS-1:0] r;
        if (s == '0)
            r = EDGE_BITS'(1);
        else if (s > EDGE_BITS'(MAX_EDGE))
            r = EDGE_BITS'(MAX_EDGE);
        else
            r = s;
        return r;
    endfunction

endpackage

@@ rtl/mcbs_req_if.sv @@
// ============================================================================
// mcbs_req_if
// request channel: valid/ready handshake with one request beat
// ============================================================================
interface mcbs_req_if
    import mcbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [POS_BITS-1:0] position;
    logic [MAG_BITS-1:0] magnitude;
    logic                has_lower_link;
    logic [TAG_BITS-1:0] item_tag;

    modport source (output valid, req_type, position, magnitude, has_lower_link, item_tag,
                    input ready);
    modport sink   (input valid, req_type, position, magnitude, has_lower_link, item_tag,
                    output ready);
endinterface

@@ rtl/mcbs_res_if.sv @@
// ============================================================================
// mcbs_res_if
// result channel: valid/ready handshake with one result beat
// ============================================================================
interface mcbs_res_if
    import mcbs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                matched;
    logic [POS_BITS-1:0] match_position;
    logic                displaced;
    logic [TAG_BITS-1:0] displaced_tag;
    logic [CNT_BITS-1:0] processed_count;

    modport source (output valid, matched, match_position, displaced, displaced_tag,
                    processed_count, input ready);
    modport sink   (input valid, matched, match_position, displaced, displaced_tag,
                    processed_count, output ready);
endinterface

@@ rtl/maxima_chain_box_search.sv @@
// ============================================================================
// maxima_chain_box_search
// coarse-scale maxima grid with box search chaining of lower maxima
// ============================================================================
// One request beat in, one result beat out, one request at a time. The grid
// lives in a single 32768-entry memory (one read, one write port, registered
// read). After reset, and after every clear request, a sweep writes every
// cell empty, one per cycle, and no request is taken until it ends. A load
// decodes the position with two divisions, then writes the cell. A chain
// request decodes the position, sets up the window and scans the n cells of
// the clipped cube, up to (2r+1)^3 (27 at radius one); the scan reads one
// cell per cycle through the memory port. A found cell that is already
// linked adds a decode of its old link position and a distance step. The
// result register lets the next request start while a result waits
// downstream.
// ============================================================================
module maxima_chain_box_search
    import mcbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    mcbs_req_if.sink                 in_ch,
    mcbs_res_if.source               out_ch,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_WIPE   = 12'b0000_0000_0010,
        ST_DIV    = 12'b0000_0000_0100,
        ST_CHECK  = 12'b0000_0000_1000,
        ST_SETUP  = 12'b0000_0001_0000,
        ST_SETUP2 = 12'b0000_0010_0000,
        ST_SETUP3 = 12'b0000_0100_0000,
        ST_SCAN   = 12'b0000_1000_0000,
        ST_DRAIN  = 12'b0001_0000_0000,
        ST_DIST   = 12'b0010_0000_0000,
        ST_WRITE  = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    // configuration
    logic [EDGE_BITS-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [RAD_BITS-1:0]  radius_reg;
    logic [SIM_BITS-1:0]  sim_reg;
    logic                 first_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= EDGE_BITS'(32);
            size_y_reg      <= EDGE_BITS'(32);
            size_z_reg      <= EDGE_BITS'(32);
            radius_reg      <= RAD_BITS'(1);
            sim_reg         <= SIM_BITS'(52429);
            first_scale_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE_X:      size_x_reg      <= cfg_data[EDGE_BITS-1:0];
                CFG_SIZE_Y:      size_y_reg      <= cfg_data[EDGE_BITS-1:0];
                CFG_SIZE_Z:      size_z_reg      <= cfg_data[EDGE_BITS-1:0];
                CFG_BOX_RADIUS:  radius_reg      <= cfg_data[RAD_BITS-1:0];
                CFG_SIMILARITY:  sim_reg         <= cfg_data[SIM_BITS-1:0];
                CFG_FIRST_SCALE: first_scale_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped grid extents
    logic [EDGE_BITS-1:0] sx, sy, sz;
    assign sx = eff_size(size_x_reg);
    assign sy = eff_size(size_y_reg);
    assign sz = eff_size(size_z_reg);

    // ------------------------------------------------------------------
    // grid memory
    // ------------------------------------------------------------------
    cell_t               mem [CELLS];
    cell_t               mem_q;
    logic                mem_we;
    logic [POS_BITS-1:0] mem_waddr;
    cell_t               mem_wdata;
    logic [POS_BITS-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[addr_reg];
    end

    // ------------------------------------------------------------------
    // request latch and working registers
    // ------------------------------------------------------------------
    logic [1:0]          req_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [MAG_BITS-1:0] mag_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [POS_BITS-1:0] wipe_reg;
    logic                boot_reg;       // sweep after reset, no result

    // shared restoring divider, one quotient bit per cycle
    logic [POS_BITS-1:0]   div_num_reg;
    logic [EDGE_BITS-1:0]  div_rem_reg;
    logic [3:0]            div_cnt_reg;
    logic                  div_stage_reg;  // 0: by sx, 1: by sy
    logic                  div_old_reg;    // decoding the old link position
    logic [EDGE_BITS-1:0]  div_den;
    logic [EDGE_BITS:0]    div_shift;
    logic                  div_ge;
    logic [EDGE_BITS-1:0]  div_rem_next;
    logic [POS_BITS-1:0]   div_num_next;

    assign div_den      = div_stage_reg ? sy : sx;
    assign div_shift    = {div_rem_reg, div_num_reg[POS_BITS-1]};
    assign div_ge       = div_shift >= {1'b0, div_den};
    assign div_rem_next = div_ge ? EDGE_BITS'(div_shift - {1'b0, div_den})
                                 : div_shift[EDGE_BITS-1:0];
    assign div_num_next = {div_num_reg[POS_BITS-2:0], div_ge};

    // decoded coordinates, the center during a scan
    logic [COORD_BITS-1:0] dec_x_reg, dec_y_reg;
    logic [POS_BITS-1:0]   dec_z_reg;

    // search window, inclusive bounds
    logic [COORD_BITS-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, z_lo_reg, z_hi_reg;
    logic [10:0]           sxy_reg;
    logic [POS_BITS-1:0]   yoff_reg, zoff_reg;
    logic [47:0]           sl_reg;         // similarity times lower magnitude

    function automatic logic [COORD_BITS-1:0] win_lo(input logic [COORD_BITS-1:0] c,
                                                     input logic [RAD_BITS-1:0] r);
        logic [COORD_BITS-1:0] v;
        if (c >= COORD_BITS'(r))
            v = c - COORD_BITS'(r);
        else
            v = '0;
        return v;
    endfunction

    function automatic logic [COORD_BITS-1:0] win_hi(input logic [COORD_BITS-1:0] c,
                                                     input logic [RAD_BITS-1:0] r,
                                                     input logic [EDGE_BITS-1:0] s);
        logic [EDGE_BITS-1:0] t;
        logic [EDGE_BITS-1:0] m;
        t = {1'b0, c} + EDGE_BITS'(r);
        m = s - EDGE_BITS'(1);
        if (t >= s)
            t = m;
        return t[COORD_BITS-1:0];
    endfunction

    function automatic logic [2:0] adiff(input logic [COORD_BITS-1:0] a,
                                         input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return d[2:0];
    endfunction

    // scan walkers
    logic [COORD_BITS-1:0] sc_x_reg, sc_y_reg, sc_z_reg;
    logic [POS_BITS-1:0]   col_reg, row_reg;
    logic [2:0]            ax, ay, az;
    logic [7:0]            dd_now;

    assign ax = adiff(sc_x_reg, dec_x_reg);
    assign ay = adiff(sc_y_reg, dec_y_reg);
    assign az = adiff(sc_z_reg, dec_z_reg[COORD_BITS-1:0]);
    assign dd_now = 8'(ax * ax) + 8'(ay * ay) + 8'(az * az);

    // best candidate
    logic                  found_reg;
    logic [7:0]            best_d_reg;
    logic [POS_BITS-1:0]   best_addr_reg;
    logic [COORD_BITS-1:0] best_x_reg, best_y_reg, best_z_reg;
    cell_t                 best_word_reg;

    // scan pipeline: read, multiply, compare
    logic                  p1_v_reg, p2_v_reg;
    logic [7:0]            p1_dd_reg, p2_dd_reg;
    logic [POS_BITS-1:0]   p1_addr_reg, p2_addr_reg;
    logic [COORD_BITS-1:0] p1_x_reg, p1_y_reg, p1_z_reg;
    logic [COORD_BITS-1:0] p2_x_reg, p2_y_reg, p2_z_reg;
    cell_t                 p2_word_reg;
    logic [47:0]           p2_us_reg;
    logic                  hit;

    assign hit = p2_v_reg && p2_word_reg.valid
              && (!found_reg || (p2_dd_reg < best_d_reg))
              && ({p2_word_reg.mag, 16'b0} > sl_reg)
              && (p2_us_reg < {mag_reg, 16'b0});

    // distance of the old link
    logic [1:0]            axis_reg;
    logic [29:0]           sq_reg;
    logic [31:0]           acc_reg;
    logic [31:0]           dsum;
    logic [POS_BITS-1:0]   da, db, dabs;

    assign dsum = acc_reg + 32'(sq_reg);
    always_comb
    begin
        case (axis_reg)
            2'd0:    begin da = POS_BITS'(dec_x_reg); db = POS_BITS'(best_x_reg); end
            2'd1:    begin da = POS_BITS'(dec_y_reg); db = POS_BITS'(best_y_reg); end
            default: begin da = dec_z_reg;            db = POS_BITS'(best_z_reg); end
        endcase
        dabs = (da >= db) ? da - db : db - da;
    end

    // pending result
    logic                res_match_reg, res_disp_reg;
    logic [POS_BITS-1:0] res_pos_reg;
    logic [TAG_BITS-1:0] res_tag_reg;

    // output register
    logic                out_valid_reg, out_match_reg, out_disp_reg;
    logic [POS_BITS-1:0] out_pos_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [CNT_BITS-1:0] out_cnt_reg;

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.matched         = out_match_reg;
    assign out_ch.match_position  = out_pos_reg;
    assign out_ch.displaced       = out_disp_reg;
    assign out_ch.displaced_tag   = out_tag_reg;
    assign out_ch.processed_count = out_cnt_reg;

    logic in_fire;
    assign in_fire = in_ch.valid && in_ch.ready;

    // memory write select: sweep, load, link
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_WIPE)
        begin
            mem_we    = 1'b1;
            mem_waddr = wipe_reg;
        end
        else if (state_reg == ST_CHECK && !div_old_reg && req_reg == REQ_LOAD
                 && dec_z_reg < POS_BITS'(sz))
        begin
            mem_we         = 1'b1;
            mem_waddr      = pos_reg;
            mem_wdata.valid = 1'b1;
            mem_wdata.mag  = mag_reg;
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_we             = 1'b1;
            mem_wdata.valid    = 1'b1;
            mem_wdata.linked   = 1'b1;
            mem_wdata.mag      = best_word_reg.mag;
            mem_wdata.link_pos = pos_reg;
            mem_wdata.link_tag = tag_reg;
        end
    end

    // ------------------------------------------------------------------
    // control sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            wipe_reg      <= '0;
            boot_reg      <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            // result register: load when free or draining, else clear on accept
            if (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            // scan pipeline advances every cycle
            p1_v_reg <= (state_reg == ST_SCAN);
            p2_v_reg <= p1_v_reg;
            if (hit)
                found_reg <= 1'b1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_match_reg <= 1'b0;
                        res_disp_reg  <= 1'b0;
                        res_pos_reg   <= '0;
                        res_tag_reg   <= '0;
                        found_reg     <= 1'b0;
                        div_num_reg   <= in_ch.position;
                        div_rem_reg   <= '0;
                        div_cnt_reg   <= '0;
                        div_stage_reg <= 1'b0;
                        div_old_reg   <= 1'b0;
                        case (in_ch.req_type)
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                                wipe_reg  <= '0;
                                state_reg <= ST_WIPE;
                            end
                            REQ_LOAD:
                                state_reg <= ST_DIV;
                            REQ_CHAIN:
                            begin
                                if (first_scale_reg || in_ch.has_lower_link)
                                begin
                                    if (count_reg != '1)
                                        count_reg <= count_reg + CNT_BITS'(1);
                                    state_reg <= ST_DIV;
                                end
                                else
                                    state_reg <= ST_DONE;
                            end
                            default:
                                state_reg <= ST_DONE;
                        endcase
                    end
                end

                ST_WIPE:
                begin
                    wipe_reg <= wipe_reg + POS_BITS'(1);
                    if (wipe_reg == POS_BITS'(CELLS - 1))
                    begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_DONE;
                    end
                end

                ST_DIV:
                begin
                    div_num_reg <= div_num_next;
                    if (div_cnt_reg == 4'(POS_BITS - 1))
                    begin
                        div_cnt_reg <= '0;
                        if (!div_stage_reg)
                        begin
                            dec_x_reg     <= div_rem_next[COORD_BITS-1:0];
                            div_rem_reg   <= '0;
                            div_stage_reg <= 1'b1;
                        end
                        else
                        begin
                            div_rem_reg <= div_rem_next;
                            dec_y_reg   <= div_rem_next[COORD_BITS-1:0];
                            dec_z_reg   <= div_num_next;
                            state_reg   <= div_old_reg ? ST_DIST : ST_CHECK;
                            axis_reg    <= '0;
                            acc_reg     <= '0;
                            sq_reg      <= '0;
                        end
                    end
                    else
                    begin
                        div_rem_reg <= div_rem_next;
                        div_cnt_reg <= div_cnt_reg + 4'd1;
                    end
                end

                ST_CHECK:
                begin
                    // outside the grid: load ignored, chain finds nothing
                    if (dec_z_reg >= POS_BITS'(sz) || req_reg == REQ_LOAD)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_SETUP;
                end

                ST_SETUP:
                begin
                    x_lo_reg <= win_lo(dec_x_reg, radius_reg);
                    x_hi_reg <= win_hi(dec_x_reg, radius_reg, sx);
                    y_lo_reg <= win_lo(dec_y_reg, radius_reg);
                    y_hi_reg <= win_hi(dec_y_reg, radius_reg, sy);
                    z_lo_reg <= win_lo(dec_z_reg[COORD_BITS-1:0], radius_reg);
                    z_hi_reg <= win_hi(dec_z_reg[COORD_BITS-1:0], radius_reg, sz);
                    sxy_reg  <= 11'(sx * sy);
                    sl_reg   <= 48'(sim_reg * mag_reg);
                    state_reg <= ST_SETUP2;
                end

                ST_SETUP2:
                begin
                    yoff_reg  <= POS_BITS'(sx * y_lo_reg);
                    zoff_reg  <= POS_BITS'(sxy_reg * z_lo_reg);
                    state_reg <= ST_SETUP3;
                end

                ST_SETUP3:
                begin
                    sc_x_reg  <= x_lo_reg;
                    sc_y_reg  <= y_lo_reg;
                    sc_z_reg  <= z_lo_reg;
                    col_reg   <= POS_BITS'(x_lo_reg);
                    row_reg   <= POS_BITS'(x_lo_reg) + yoff_reg;
                    addr_reg  <= POS_BITS'(x_lo_reg) + yoff_reg + zoff_reg;
                    state_reg <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    // z innermost, then y, then x
                    if (sc_z_reg != z_hi_reg)
                    begin
                        sc_z_reg <= sc_z_reg + COORD_BITS'(1);
                        addr_reg <= addr_reg + POS_BITS'(sxy_reg);
                    end
                    else if (sc_y_reg != y_hi_reg)
                    begin
                        sc_y_reg <= sc_y_reg + COORD_BITS'(1);
                        sc_z_reg <= z_lo_reg;
                        row_reg  <= row_reg + POS_BITS'(sx);
                        addr_reg <= row_reg + POS_BITS'(sx) + zoff_reg;
                    end
                    else if (sc_x_reg != x_hi_reg)
                    begin
                        sc_x_reg <= sc_x_reg + COORD_BITS'(1);
                        sc_y_reg <= y_lo_reg;
                        sc_z_reg <= z_lo_reg;
                        col_reg  <= col_reg + POS_BITS'(1);
                        row_reg  <= col_reg + POS_BITS'(1) + yoff_reg;
                        addr_reg <= col_reg + POS_BITS'(1) + yoff_reg + zoff_reg;
                    end
                    else
                        state_reg <= ST_DRAIN;
                end

                ST_DRAIN:
                begin
                    if (!p1_v_reg && !p2_v_reg)
                    begin
                        if (!found_reg)
                            state_reg <= ST_DONE;
                        else if (best_word_reg.linked)
                        begin
                            div_num_reg   <= best_word_reg.link_pos;
                            div_rem_reg   <= '0;
                            div_cnt_reg   <= '0;
                            div_stage_reg <= 1'b0;
                            div_old_reg   <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                        else
                            state_reg <= ST_WRITE;
                    end
                end

                ST_DIST:
                begin
                    sq_reg   <= 30'(dabs * dabs);
                    acc_reg  <= dsum;
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd3)
                    begin
                        // new maximum must be strictly nearer than the old one
                        if (32'(best_d_reg) < dsum)
                        begin
                            res_disp_reg <= 1'b1;
                            res_tag_reg  <= best_word_reg.link_tag;
                            state_reg    <= ST_WRITE;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end

                ST_WRITE:
                begin
                    res_match_reg <= 1'b1;
                    res_pos_reg   <= best_addr_reg;
                    state_reg     <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                        state_reg <= ST_IDLE;
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_ch.req_type;
            pos_reg <= in_ch.position;
            mag_reg <= in_ch.magnitude;
            tag_reg <= in_ch.item_tag;
        end

        p1_dd_reg   <= dd_now;
        p1_addr_reg <= addr_reg;
        p1_x_reg    <= sc_x_reg;
        p1_y_reg    <= sc_y_reg;
        p1_z_reg    <= sc_z_reg;

        p2_dd_reg   <= p1_dd_reg;
        p2_addr_reg <= p1_addr_reg;
        p2_x_reg    <= p1_x_reg;
        p2_y_reg    <= p1_y_reg;
        p2_z_reg    <= p1_z_reg;
        p2_word_reg <= mem_q;
        p2_us_reg   <= 48'(mem_q.mag * sim_reg);

        if (hit)
        begin
            best_d_reg    <= p2_dd_reg;
            best_addr_reg <= p2_addr_reg;
            best_x_reg    <= p2_x_reg;
            best_y_reg    <= p2_y_reg;
            best_z_reg    <= p2_z_reg;
            best_word_reg <= p2_word_reg;
        end

        if (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready))
        begin
            out_match_reg <= res_match_reg;
            out_pos_reg   <= res_pos_reg;
            out_disp_reg  <= res_disp_reg;
            out_tag_reg   <= res_tag_reg;
            out_cnt_reg   <= count_reg;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `include "maxima_chain_box_search_assert.svh"

    `MCBS_ASSERT_NOW(a_no_write_in_scan, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN), !mem_we, "grid written during a scan")
    `MCBS_ASSERT_NEXT(a_clear_sweeps, in_fire && (in_ch.req_type == REQ_CLEAR), (state_reg == ST_WIPE) && (count_reg == '0) && (wipe_reg == '0), "clear did not start a sweep")
    `MCBS_ASSERT_NOW(a_disp_needs_match, out_valid_reg && out_disp_reg, out_match_reg, "displacement reported without a match")
    `MCBS_ASSERT_NOW(a_link_write_found, state_reg == ST_WRITE, found_reg, "link written without a candidate")

endmodule

@@ bench/maxima_chain_box_search_tb.sv @@
// ----------------------------------------------------------------------------
// maxima_chain_box_search_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the maxima chaining grid. Request beats are sent
// through the request channel. A scoreboard with its own copy of the grid
// works out each result beat, and compares the result beats in order. The
// run goes through several grid sizes, radii and similarity bounds. It uses
// random gaps and stalls on both channels, and holds the result side off
// for a long stretch once.
// ----------------------------------------------------------------------------
module maxima_chain_box_search_tb;
    import mcbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;  // outlasts a clear sweep and a chain at r=7
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]          kind;
        logic [POS_BITS-1:0] pos;
        logic [MAG_BITS-1:0] mag;
        logic                lower_link;
        logic [TAG_BITS-1:0] tag;
    } grid_req_t;

    typedef struct packed {
        logic                matched;
        logic [POS_BITS-1:0] match_pos;
        logic                displaced;
        logic [TAG_BITS-1:0] disp_tag;
        logic [CNT_BITS-1:0] count;
    } link_result_t;

    // ------------------------------------------------------------------
    // scoreboard: private copy of the grid and the queue of due results
    // ------------------------------------------------------------------
    class link_scoreboard;
        bit                  occupied [CELLS];
        logic [MAG_BITS-1:0] cell_mag [CELLS];
        bit                  has_link [CELLS];
        logic [POS_BITS-1:0] link_pos [CELLS];
        logic [TAG_BITS-1:0] link_tag [CELLS];
        logic [CNT_BITS-1:0] chain_cnt;
        logic [EDGE_BITS-1:0] sz_x, sz_y, sz_z;
        logic [RAD_BITS-1:0]  radius;
        logic [SIM_BITS-1:0]  sim;
        logic                 first_scale;
        link_result_t due_q[$];
        int mismatches, checked, chains, links, takeovers;

        function new();
            sz_x = EDGE_BITS'(32); sz_y = EDGE_BITS'(32); sz_z = EDGE_BITS'(32);
            radius = RAD_BITS'(1); sim = 16'd52429; first_scale = 1'b0;
            chain_cnt = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
            case (idx)
                CFG_SIZE_X:      sz_x = v[EDGE_BITS-1:0];
                CFG_SIZE_Y:      sz_y = v[EDGE_BITS-1:0];
                CFG_SIZE_Z:      sz_z = v[EDGE_BITS-1:0];
                CFG_BOX_RADIUS:  radius = v[RAD_BITS-1:0];
                CFG_SIMILARITY:  sim = v[SIM_BITS-1:0];
                CFG_FIRST_SCALE: first_scale = v[0];
                default: ;
            endcase
        endfunction

        function int edge_of(logic [EDGE_BITS-1:0] s);
            if (s == 0)
                return 1;
            if (s > MAX_EDGE)
                return MAX_EDGE;
            return int'(s);
        endfunction

        function int sq_dist(int a, int b, int sx, int sy);
            int ax, ay, az, bx, by, bz;
            ax = a % sx; ay = (a / sx) % sy; az = (a / sx) / sy;
            bx = b % sx; by = (b / sx) % sy; bz = (b / sx) / sy;
            return (ax-bx)*(ax-bx) + (ay-by)*(ay-by) + (az-bz)*(az-bz);
        endfunction

        // upper/lower strictly inside (sim/65536, 65536/sim), exact in 64 bits
        function bit in_ratio(logic [MAG_BITS-1:0] up, logic [MAG_BITS-1:0] low);
            longint unsigned u, l, s;
            u = up; l = low; s = sim;
            return (u * 65536 > s * l) && (u * s < l * 65536);
        endfunction

        function void note_request(grid_req_t rq);
            link_result_t res;
            int sx, sy, sz, total, r, cx, cy, cz, best_d, best, dd, d;
            bit found;
            res = '0;
            sx = edge_of(sz_x); sy = edge_of(sz_y); sz = edge_of(sz_z);
            total = sx * sy * sz;
            if (rq.kind == REQ_CLEAR)
            begin
                foreach (occupied[i])
                begin
                    occupied[i] = 0;
                    has_link[i] = 0;
                end
                chain_cnt = 0;
            end
            else if (rq.kind == REQ_LOAD)
            begin
                if (int'(rq.pos) < total)
                begin
                    occupied[rq.pos] = 1;
                    cell_mag[rq.pos] = rq.mag;
                    has_link[rq.pos] = 0;
                end
            end
            else if (rq.kind == REQ_CHAIN && (first_scale || rq.lower_link))
            begin
                chains++;
                if (chain_cnt != 16'hFFFF)
                    chain_cnt++;
                if (int'(rq.pos) < total)
                begin
                    r = (radius > 7) ? 7 : int'(radius);
                    cx = rq.pos % sx; cy = (rq.pos / sx) % sy; cz = (rq.pos / sx) / sy;
                    best_d = 10000000; best = 0; found = 0;
                    // x outermost, then y, then z; first strictly better wins
                    for (int x = (cx-r < 0 ? 0 : cx-r); x < (cx+r+1 > sx ? sx : cx+r+1); x++)
                        for (int y = (cy-r < 0 ? 0 : cy-r); y < (cy+r+1 > sy ? sy : cy+r+1); y++)
                            for (int z = (cz-r < 0 ? 0 : cz-r);
                                 z < (cz+r+1 > sz ? sz : cz+r+1); z++)
                            begin
                                d = x + sx * (y + sy * z);
                                if (occupied[d])
                                begin
                                    dd = (x-cx)*(x-cx) + (y-cy)*(y-cy) + (z-cz)*(z-cz);
                                    if (dd < best_d && in_ratio(cell_mag[d], rq.mag))
                                    begin
                                        best_d = dd; best = d; found = 1;
                                    end
                                end
                            end
                    if (found)
                    begin
                        if (!has_link[best] ||
                            sq_dist(rq.pos, best, sx, sy) < sq_dist(link_pos[best], best, sx, sy))
                        begin
                            if (has_link[best])
                            begin
                                res.displaced = 1;
                                res.disp_tag  = link_tag[best];
                            end
                            has_link[best] = 1;
                            link_pos[best] = rq.pos;
                            link_tag[best] = rq.tag;
                            res.matched    = 1;
                            res.match_pos  = best[POS_BITS-1:0];
                        end
                    end
                end
            end
            res.count = chain_cnt;
            due_q.push_back(res);
        endfunction

        function void check_result(link_result_t got);
            link_result_t want;
            checked++;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result beat with none due: %p", $realtime, got);
                return;
            end
            want = due_q.pop_front();
            if (got.matched)
                links++;
            if (got.displaced)
                takeovers++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result mismatch: exp %p got %p", $realtime, want, got);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    mcbs_req_if req_ch();
    mcbs_res_if res_ch();

    maxima_chain_box_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    link_scoreboard sb;

    // bench-side view of the grid shape, for steering positions
    int  grid_x, grid_y, grid_z, grid_r;
    bit  hold_off;      // asks the result side for one long stall
    bit  no_gaps;       // a phase with back-to-back request beats
    int  idle_cycles;
    int  phases;
    int  loaded_pos[$];
    logic [MAG_BITS-1:0] loaded_mag[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(80, 300);
    endfunction

    // result side: random stalls, plus the one long hold-off
    initial
    begin
        int g;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // beat monitors and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request({req_ch.req_type, req_ch.position, req_ch.magnitude,
                                 req_ch.has_lower_link, req_ch.item_tag});
            if (res_ch.valid && res_ch.ready)
                sb.check_result({res_ch.matched, res_ch.match_position, res_ch.displaced,
                                 res_ch.displaced_tag, res_ch.processed_count});
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // one request beat; valid stays up when no gap follows
    task automatic send_req(logic [1:0] kind, int pos, logic [MAG_BITS-1:0] mag,
                            logic lower_link, logic [TAG_BITS-1:0] tag);
        int g;
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.position       <= pos[POS_BITS-1:0];
        req_ch.magnitude      <= mag;
        req_ch.has_lower_link <= lower_link;
        req_ch.item_tag       <= tag;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        g = no_gaps ? 0 : gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // wait for all results, let the block settle, then write every register
    task automatic set_grid(int sx, int sy, int sz, int r, int sim, int fs);
        logic [CFG_DATA_BITS-1:0] vals [6];
        logic [CFG_IDX_BITS-1:0]  idx [6];
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        idx  = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_BOX_RADIUS, CFG_SIMILARITY,
                 CFG_FIRST_SCALE};
        vals = '{CFG_DATA_BITS'(sx), CFG_DATA_BITS'(sy), CFG_DATA_BITS'(sz),
                 CFG_DATA_BITS'(r), CFG_DATA_BITS'(sim), CFG_DATA_BITS'(fs)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
        grid_x = sx; grid_y = sy; grid_z = sz; grid_r = r;
        phases++;
    endtask

    // a cell near an upper maximum, clamped into the grid
    function automatic int near_cell(int base);
        int x, y, z, span;
        span = grid_r + 1;
        x = base % grid_x + $urandom_range(0, 2*span) - span;
        y = (base / grid_x) % grid_y + $urandom_range(0, 2*span) - span;
        z = (base / grid_x) / grid_y + $urandom_range(0, 2*span) - span;
        x = x < 0 ? 0 : (x >= grid_x ? grid_x-1 : x);
        y = y < 0 ? 0 : (y >= grid_y ? grid_y-1 : y);
        z = z < 0 ? 0 : (z >= grid_z ? grid_z-1 : z);
        return x + grid_x * (y + grid_y * z);
    endfunction

    // clear, then mostly loads and well-aimed chain beats, some noise
    task automatic random_phase(int n, bit squeeze);
        int r, k, total, pos;
        logic [MAG_BITS-1:0] m;
        longint unsigned scaled;
        total = grid_x * grid_y * grid_z;
        send_req(REQ_CLEAR, $urandom_range(0, 32767), $urandom, 1'($urandom_range(0, 1)),
                 16'($urandom));
        loaded_pos.delete();
        loaded_mag.delete();
        for (int i = 0; i < n; i++)
        begin
            // after the sweep: sender keeps offering while the result side sits still
            if (squeeze && i == 20)
                hold_off = 1;
            r = $urandom_range(0, 99);
            if (loaded_pos.size() == 0 || r < 30)
            begin
                pos = ($urandom_range(0, 9) != 0) ? $urandom_range(0, total-1)
                                                  : $urandom_range(0, 32767);
                m = ($urandom_range(0, 4) != 0) ? $urandom : $urandom_range(0, 16'hFFFF);
                send_req(REQ_LOAD, pos, m, 1'($urandom_range(0, 1)), 16'($urandom));
                if (pos < total)
                begin
                    loaded_pos.push_back(pos);
                    loaded_mag.push_back(m);
                end
            end
            else if (r < 94)
            begin
                k = $urandom_range(0, loaded_pos.size()-1);
                r = $urandom_range(0, 99);
                if (r < 10)
                    m = loaded_mag[k];
                else if (r < 15)
                    m = '0;
                else
                begin
                    scaled = longint'(loaded_mag[k]) * $urandom_range(60, 160) / 100;
                    m = (scaled > 32'hFFFFFFFF) ? 32'hFFFFFFFF : scaled[31:0];
                end
                send_req(REQ_CHAIN, near_cell(loaded_pos[k]), m,
                         $urandom_range(0, 99) < 85, 16'($urandom));
            end
            else
                send_req(REQ_CHAIN, $urandom_range(0, 32767), $urandom,
                         1'($urandom_range(0, 1)), 16'($urandom));
        end
    endtask

    initial
    begin
        int p5285;
        sb = new();
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.req_type       <= REQ_CLEAR;
        req_ch.position       <= '0;
        req_ch.magnitude      <= '0;
        req_ch.has_lower_link <= 1'b0;
        req_ch.item_tag       <= '0;
        grid_x = 32; grid_y = 32; grid_z = 32; grid_r = 1;
        idle_cycles = 0; phases = 0; hold_off = 0; no_gaps = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part at reset settings: 32^3 grid, radius one ----
        p5285 = 5 + 5*32 + 5*1024;
        send_req(REQ_LOAD,  0,     32'hFFFFFFFF, 1'b0, 16'h0000);
        send_req(REQ_LOAD,  32767, 32'h00010000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, 32767, 32'h00010000, 1'b1, 16'hFFFF);  // far corner, clipped cube
        send_req(REQ_CHAIN, 0,     32'hFFFFFFFF, 1'b0, 16'h0011);  // not chained, no link below
        send_req(REQ_CHAIN, 0,     32'hFFFFFFFF, 1'b1, 16'h0001);  // near corner
        send_req(REQ_CHAIN, 1,     32'h00000000, 1'b1, 16'h0002);  // zero lower never matches
        send_req(REQ_LOAD,  p5285, 32'h00100000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, p5285+1, 32'h00100000, 1'b1, 16'h00AA);
        send_req(REQ_CHAIN, p5285,   32'h000F0000, 1'b1, 16'h0055);  // nearer: takes over
        send_req(REQ_CHAIN, p5285+32, 32'h00100000, 1'b1, 16'h0077); // not nearer: no link
        send_req(REQ_CHAIN, p5285+1024, 32'h00200000, 1'b1, 16'h0078); // ratio out of bounds
        send_req(REQ_LOAD,  p5285,   32'h00100000, 1'b0, 16'h0000);  // reload drops the link
        send_req(REQ_LOAD,  p5285+2, 32'h00140000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, p5285+1, 32'h00100000, 1'b1, 16'h0003);  // p5285+2 fails the ratio
        send_req(REQ_LOAD,  1000,    32'h00000000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, 1001,    32'h00000001, 1'b1, 16'h0004);

        // small grid: beats that fall outside it
        set_grid(3, 5, 2, 1, 52429, 0);
        send_req(REQ_CHAIN, 100, 32'h00010000, 1'b1, 16'h0005);  // counted, no match
        send_req(REQ_LOAD,  100, 32'h00010000, 1'b0, 16'h0000);  // dropped
        send_req(REQ_LOAD,  29,  32'h00010000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, 29,  32'h00010000, 1'b1, 16'h0006);
        send_req(REQ_CLEAR, 0,   32'h00000000, 1'b0, 16'h0000);
        send_req(REQ_CHAIN, 29,  32'h00010000, 1'b1, 16'h0007);  // count restarts after clear

        // ---- random phases ----
        set_grid(32, 32, 32, 7, 1, 1);          // widest cube, loosest bound
        random_phase(40, 0);
        set_grid(1, 1, 1, 0, 65535, 0);         // single cell, tightest bound
        random_phase(120, 0);
        for (int ph = 0; ph < 7; ph++)
        begin
            set_grid($urandom_range(1, 8), $urandom_range(1, 8),
                     (ph == 3) ? 32 : $urandom_range(1, 8), $urandom_range(0, 3),
                     (ph == 5) ? 65535 : $urandom_range(30000, 65535), $urandom_range(0, 1));
            no_gaps = (ph == 2);
            random_phase(160, ph == 1);
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d grid settings, %0d results checked, %0d chain beats taken",
                 phases, sb.checked, sb.chains);
        $display("links made %0d, links taken over %0d, mismatches %0d",
                 sb.links, sb.takeovers, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ maxima_chain_box_search.f @@
+incdir+rtl
rtl/mcbs_pkg.sv
rtl/mcbs_req_if.sv
rtl/mcbs_res_if.sv
rtl/maxima_chain_box_search.sv
bench/maxima_chain_box_search_tb.sv
